### rtl/cts_pkg.sv
// ----------------------------------------------------------------------------
// cts_pkg
// Shared types and constants for the contingency table scorer.
// ----------------------------------------------------------------------------
package cts_pkg;

    localparam int COUNT_BITS_DEF = 32;
    localparam int SAMPLE_BITS    = 16;
    localparam int OUT_COUNT_BITS = 32;
    localparam int FRAC_SHIFT     = 14;
    localparam int SKILL_SHIFT    = 15;
    localparam int BIAS_SHIFT     = 8;
    localparam logic [15:0] FRAC_CAP = 16'd16384;
    localparam logic [15:0] BIAS_CAP = 16'd65535;

    // configuration register indexes
    localparam logic [1:0] CFG_F_LO = 2'd0;
    localparam logic [1:0] CFG_F_HI = 2'd1;
    localparam logic [1:0] CFG_O_LO = 2'd2;
    localparam logic [1:0] CFG_O_HI = 2'd3;

    // multiply jobs
    localparam logic [2:0] MUL_YY  = 3'd0;
    localparam logic [2:0] MUL_ZZ  = 3'd1;
    localparam logic [2:0] MUL_XW  = 3'd2;
    localparam logic [2:0] MUL_YZ  = 3'd3;
    localparam logic [2:0] MUL_SUM = 3'd4;
    localparam logic [2:0] MUL_LAST = MUL_SUM;

    // divide jobs
    localparam logic [2:0] DIV_POD  = 3'd0;
    localparam logic [2:0] DIV_PODN = 3'd1;
    localparam logic [2:0] DIV_FAR  = 3'd2;
    localparam logic [2:0] DIV_CSI  = 3'd3;
    localparam logic [2:0] DIV_HSS  = 3'd4;
    localparam logic [2:0] DIV_BIAS = 3'd5;
    localparam logic [2:0] DIV_LAST = DIV_BIAS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_LOAD,
        S_MUL_RUN,
        S_MUL_STORE,
        S_DIV_LOAD,
        S_DIV_RUN,
        S_DIV_STORE,
        S_OUT
    } t_state;

    typedef struct packed {
        logic       count;
        logic       mul_load;
        logic       mul_step;
        logic       mul_store;
        logic       div_load;
        logic       div_step;
        logic       div_store;
        logic       out_load;
        logic [2:0] job;
    } t_cmd;

    typedef struct packed {
        logic out_busy;
    } t_status;

endpackage

### rtl/cts_ctrl.sv
// ----------------------------------------------------------------------------
// cts_ctrl
// Sequencer: counts items, then runs the multiply and divide jobs of a report.
// ----------------------------------------------------------------------------
module cts_ctrl import cts_pkg::*; #(
    parameter int MUL_STEPS = COUNT_BITS_DEF + 1,
    parameter int DIV_STEPS = 2 * COUNT_BITS_DEF + 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_last,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam int CW = $clog2(DIV_STEPS + 1);

    t_state r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [2:0]    r_job, n_job;
    logic          w_mul_end, w_div_end, w_acc;

    assign w_mul_end = (r_cnt == CW'(MUL_STEPS - 1));
    assign w_div_end = (r_cnt == CW'(DIV_STEPS - 1));
    assign w_acc     = i_in_valid && (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_job   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_job   <= n_job;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_job   = r_job;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc && i_in_last) begin
                    n_state = S_MUL_LOAD;
                    n_job   = MUL_YY;
                end
            end
            S_MUL_LOAD: begin
                n_state = S_MUL_RUN;
                n_cnt   = '0;
            end
            S_MUL_RUN: begin
                n_cnt = r_cnt + 1'b1;
                if (w_mul_end) n_state = S_MUL_STORE;
            end
            S_MUL_STORE: begin
                if (r_job == MUL_LAST) begin
                    n_state = S_DIV_LOAD;
                    n_job   = DIV_POD;
                end else begin
                    n_state = S_MUL_LOAD;
                    n_job   = r_job + 1'b1;
                end
            end
            S_DIV_LOAD: begin
                n_state = S_DIV_RUN;
                n_cnt   = '0;
            end
            S_DIV_RUN: begin
                n_cnt = r_cnt + 1'b1;
                if (w_div_end) n_state = S_DIV_STORE;
            end
            S_DIV_STORE: begin
                if (r_job == DIV_LAST) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_DIV_LOAD;
                    n_job   = r_job + 1'b1;
                end
            end
            S_OUT: begin
                if (!i_status.out_busy) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_cmd.job  = r_job;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.count = w_acc;
            end
            S_MUL_LOAD:  o_cmd.mul_load  = 1'b1;
            S_MUL_RUN:   o_cmd.mul_step  = 1'b1;
            S_MUL_STORE: o_cmd.mul_store = 1'b1;
            S_DIV_LOAD:  o_cmd.div_load  = 1'b1;
            S_DIV_RUN:   o_cmd.div_step  = 1'b1;
            S_DIV_STORE: o_cmd.div_store = 1'b1;
            S_OUT:       o_cmd.out_load  = !i_status.out_busy;
            default:     o_cmd = '0;
        endcase
    end

endmodule

### rtl/cts_datapath.sv
// ----------------------------------------------------------------------------
// cts_datapath
// Counters, bounds, shift-add multiplier, restoring divider, result register.
// ----------------------------------------------------------------------------
module cts_datapath import cts_pkg::*; #(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    input  logic [1:0]             i_cfg_index,
    input  logic [SAMPLE_BITS-1:0] i_cfg_data,
    input  logic [SAMPLE_BITS-1:0] i_fcst,
    input  logic [SAMPLE_BITS-1:0] i_obs,
    input  t_cmd                   i_cmd,
    output t_status                o_status,
    input  logic                   i_out_ready,
    output logic                   o_out_valid,
    output logic [223:0]           o_out_data
);

    localparam int CB = COUNT_BITS;
    localparam int MW = CB + 1;
    localparam int PW = 2 * CB + 2;
    localparam int DW = 2 * CB + 4;
    localparam int NW = 2 * CB + 16;

    logic signed [SAMPLE_BITS-1:0] r_f_lo, r_f_hi, r_o_lo, r_o_hi;
    logic [CB-1:0] r_hit, r_miss, r_fa, r_cn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_lo <= '0;
            r_f_hi <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
            r_o_lo <= '0;
            r_o_hi <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_F_LO: r_f_lo <= i_cfg_data;
                CFG_F_HI: r_f_hi <= i_cfg_data;
                CFG_O_LO: r_o_lo <= i_cfg_data;
                CFG_O_HI: r_o_hi <= i_cfg_data;
                default:  ;
            endcase
        end
    end

    // classify and count
    logic w_fe, w_oe;
    assign w_fe = ($signed(i_fcst) >= r_f_lo) && ($signed(i_fcst) <= r_f_hi);
    assign w_oe = ($signed(i_obs) >= r_o_lo) && ($signed(i_obs) <= r_o_hi);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit  <= '0;
            r_miss <= '0;
            r_fa   <= '0;
            r_cn   <= '0;
        end else if (i_cmd.count) begin
            if (w_fe && w_oe) begin
                if (~&r_hit) r_hit <= r_hit + 1'b1;
            end else if (w_oe) begin
                if (~&r_miss) r_miss <= r_miss + 1'b1;
            end else if (w_fe) begin
                if (~&r_fa) r_fa <= r_fa + 1'b1;
            end else begin
                if (~&r_cn) r_cn <= r_cn + 1'b1;
            end
        end
    end

    // sums of counters
    logic [MW-1:0] w_hm, w_hf, w_cf, w_yz, w_xw;
    logic [CB+1:0] w_hmf;
    assign w_hm  = MW'(r_hit) + MW'(r_miss);
    assign w_hf  = MW'(r_hit) + MW'(r_fa);
    assign w_cf  = MW'(r_cn) + MW'(r_fa);
    assign w_yz  = MW'(r_miss) + MW'(r_fa);
    assign w_xw  = MW'(r_hit) + MW'(r_cn);
    assign w_hmf = (CB+2)'(w_hm) + (CB+2)'(r_fa);

    // shift-add multiplier
    logic [PW-1:0] r_ma, r_mp, r_pxw, r_pyz;
    logic [MW-1:0] r_mb;
    logic [DW-1:0] r_den;
    logic [MW-1:0] w_a, w_b;

    always_comb begin
        case (i_cmd.job)
            MUL_YY:  begin w_a = MW'(r_miss); w_b = MW'(r_miss); end
            MUL_ZZ:  begin w_a = MW'(r_fa);   w_b = MW'(r_fa);   end
            MUL_XW:  begin w_a = MW'(r_hit);  w_b = MW'(r_cn);   end
            MUL_YZ:  begin w_a = MW'(r_miss); w_b = MW'(r_fa);   end
            default: begin w_a = w_yz;        w_b = w_xw;        end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_load) begin
            r_ma <= PW'(w_a);
            r_mb <= w_b;
            r_mp <= '0;
        end else if (i_cmd.mul_step) begin
            if (r_mb[0]) r_mp <= r_mp + r_ma;
            r_ma <= r_ma << 1;
            r_mb <= r_mb >> 1;
        end else if (i_cmd.mul_store) begin
            case (i_cmd.job)
                MUL_YY:  r_den <= DW'(r_mp);
                MUL_XW: begin
                    r_pxw <= r_mp;
                    r_den <= r_den + (DW'(r_mp) << 1);
                end
                MUL_YZ:  r_pyz <= r_mp;
                default: r_den <= r_den + DW'(r_mp);
            endcase
        end
    end

    // restoring divider with saturating quotient
    logic          w_neg;
    logic [PW-1:0] w_diff;
    logic [NW-1:0] w_num, r_num;
    logic [DW-1:0] w_dd, r_dd, r_rem;
    logic [15:0]   w_cap, r_cap;
    logic [16:0]   r_q;
    logic          r_ovf;
    logic [DW:0]   w_rsh;
    logic [15:0]   w_mag;
    logic [15:0]   r_res [6];

    assign w_neg  = r_pxw < r_pyz;
    assign w_diff = w_neg ? (r_pyz - r_pxw) : (r_pxw - r_pyz);

    always_comb begin
        w_cap = FRAC_CAP;
        case (i_cmd.job)
            DIV_POD: begin
                w_num = NW'(r_hit) << FRAC_SHIFT;  w_dd = DW'(w_hm);
            end
            DIV_PODN: begin
                w_num = NW'(r_cn) << FRAC_SHIFT;   w_dd = DW'(w_cf);
            end
            DIV_FAR: begin
                w_num = NW'(r_fa) << FRAC_SHIFT;   w_dd = DW'(w_hf);
            end
            DIV_CSI: begin
                w_num = NW'(r_hit) << FRAC_SHIFT;  w_dd = DW'(w_hmf);
            end
            DIV_HSS: begin
                w_num = NW'(w_diff) << SKILL_SHIFT; w_dd = r_den;
            end
            default: begin
                w_num = NW'(w_hf) << BIAS_SHIFT;   w_dd = DW'(w_hm);
                w_cap = BIAS_CAP;
            end
        endcase
    end

    assign w_rsh = {r_rem, r_num[NW-1]};
    assign w_mag = (r_ovf || (r_q > {1'b0, r_cap})) ? r_cap : r_q[15:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_num <= w_num;
            r_dd  <= w_dd;
            r_cap <= w_cap;
            r_rem <= '0;
            r_q   <= '0;
            r_ovf <= 1'b0;
        end else if (i_cmd.div_step) begin
            r_num <= r_num << 1;
            r_ovf <= r_ovf | r_q[16];
            if (w_rsh >= {1'b0, r_dd}) begin
                r_rem <= DW'(w_rsh - {1'b0, r_dd});
                r_q   <= {r_q[15:0], 1'b1};
            end else begin
                r_rem <= w_rsh[DW-1:0];
                r_q   <= {r_q[15:0], 1'b0};
            end
        end else if (i_cmd.div_store) begin
            if (r_dd == '0) r_res[i_cmd.job] <= '0;
            else if (i_cmd.job == DIV_HSS && w_neg) r_res[i_cmd.job] <= 16'd0 - w_mag;
            else r_res[i_cmd.job] <= w_mag;
        end
    end

    // result register
    logic [CB+31:0] w_ex_h, w_ex_m, w_ex_f, w_ex_c;
    assign w_ex_h = {32'd0, r_hit};
    assign w_ex_m = {32'd0, r_miss};
    assign w_ex_f = {32'd0, r_fa};
    assign w_ex_c = {32'd0, r_cn};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_out_data <= {4'd0,
                           r_res[DIV_BIAS], r_res[DIV_HSS],
                           r_res[DIV_CSI][14:0], r_res[DIV_FAR][14:0],
                           r_res[DIV_PODN][14:0], r_res[DIV_POD][14:0],
                           w_ex_c[OUT_COUNT_BITS-1:0], w_ex_f[OUT_COUNT_BITS-1:0],
                           w_ex_m[OUT_COUNT_BITS-1:0], w_ex_h[OUT_COUNT_BITS-1:0]};
        end
    end

    assign o_status.out_busy = o_out_valid && !i_out_ready;

endmodule

### rtl/contingency_table_scorer_core.sv
// ----------------------------------------------------------------------------
// contingency_table_scorer_core
// Counts a 2x2 contingency table of forecast/observed events and reports
// verification scores on items marked last.
// ----------------------------------------------------------------------------
// Latency/throughput: an item without tlast is accepted while the block is
//   idle, one item per cycle. An item with tlast is counted, then blocks input
//   while five shift-add multiplies (one bit per cycle) and six restoring
//   divides of 2*COUNT_BITS+16 steps run; the report then loads into the
//   output register once it is free.
// Reset: synchronous active low; clears counters, sets bounds to defaults
//   (low 0, high 32767), drops any pending result.
// ----------------------------------------------------------------------------
module contingency_table_scorer_core import cts_pkg::*; #(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // config write channel
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [15:0]  i_cfg_data,
    // input stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,  // [15:0] forecast_sample, [31:16] observed_sample
    input  logic         s_axis_tlast,  // last_of_set
    // result stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [223:0] m_axis_tdata   // hit_count[31:0], miss_count[63:32],
                                        // false_alarm_count[95:64],
                                        // correct_negative_count[127:96],
                                        // detect_prob[142:128],
                                        // nonevent_detect_prob[157:143],
                                        // false_alarm_ratio[172:158],
                                        // success_index[187:173],
                                        // skill_score[203:188],
                                        // frequency_bias[219:204], zeros above
);

    t_cmd    w_cmd;
    t_status w_status;

    // config is taken at any time; writes must only happen while idle, which the block does not enforce
    assign o_cfg_ready = 1'b1;

    cts_ctrl #(
        .MUL_STEPS (COUNT_BITS + 1),
        .DIV_STEPS (2 * COUNT_BITS + 16)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_last  (s_axis_tlast),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    cts_datapath #(
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_fcst      (s_axis_tdata[15:0]),
        .i_obs       (s_axis_tdata[31:16]),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata)
    );

endmodule
